// File: hw/rtl/stes_pkg.sv
// Shared types and constants for the square tone envelope synth.
// Used by every module under hw/rtl; depends on nothing else.
package stes_pkg;

    localparam int unsigned SAMPLE_RATE_DEF = 16000;
    localparam int unsigned ENV_MS_DEF      = 5;

    localparam int FREQ_W  = 15;
    localparam int DUR_W   = 16;
    localparam int SMP_W   = 16;
    localparam int IDX_W   = 22;
    localparam int PHASE_W = 16;
    localparam int GAIN_W  = 17;
    localparam int VOL_W   = 8;

    localparam logic [VOL_W-1:0]  VOLUME_RESET = 8'd200;
    localparam logic [GAIN_W-1:0] GAIN_ONE     = 17'd65536;

    // note length = (dur * LEN_MULT) >> LEN_SHIFT, LEN_MULT = ceil(rate * 2^27 / 1000)
    localparam int LEN_SHIFT  = 27;
    localparam int LEN_MULT_W = 33;

    // floor(z / 255) = (z * RECIP_255) >> 32 for z < 2^24
    localparam int                 RECIP_W   = 25;
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef struct packed {
        logic              start_note;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUR_W-1:0]  duration_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    note_done;
        logic                    past_end;
    } out_item_t;

    typedef struct packed {
        logic active;
        logic done;
        logic past;
        logic pos;
    } tone_flags_t;

    typedef struct packed {
        logic             valid;
        tone_flags_t      flags;
        logic [IDX_W-1:0] s;
        logic [IDX_W-1:0] ns;
    } note_stage_t;

    typedef struct packed {
        logic              valid;
        tone_flags_t       flags;
        logic [GAIN_W-1:0] gain;
    } gain_stage_t;

endpackage

// File: hw/rtl/stes_note_ctrl.sv
// Input register and note state: length, sample counter, phase accumulator.
// Depends on stes_pkg.
module stes_note_ctrl #(
    parameter int unsigned SAMPLE_RATE = stes_pkg::SAMPLE_RATE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  stes_pkg::in_item_t    in_item,
    output stes_pkg::note_stage_t stage,
    input  logic                  stage_ready
);

    localparam int IW = stes_pkg::IDX_W;
    localparam int PW = stes_pkg::PHASE_W;
    localparam int FW = stes_pkg::FREQ_W;
    localparam int DW = stes_pkg::DUR_W;
    localparam int MW = stes_pkg::LEN_MULT_W;
    localparam int PRW = DW + MW;
    localparam logic [63:0] LEN_MULT_FULL =
        ((64'(SAMPLE_RATE) << stes_pkg::LEN_SHIFT) + 64'd999) / 64'd1000;
    localparam logic [MW-1:0] LEN_MULT = LEN_MULT_FULL[MW-1:0];
    localparam int unsigned Q_MAX = ((1 << FW) - 1) / SAMPLE_RATE;
    localparam logic [PW:0] RATE_X = (PW + 1)'(SAMPLE_RATE);

    logic          en0;
    logic          en1;
    logic [PW:0]   fsub;
    logic [PW-1:0] fmod;
    logic [PRW-1:0] len_prod;

    logic          v0_reg, v0_next;
    logic          start0_reg, start0_next;
    logic          fnz0_reg, fnz0_next;
    logic [PW-1:0] fmod0_reg, fmod0_next;
    logic [IW-1:0] len0_reg, len0_next;

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] len_reg, len_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic          fnz_reg, fnz_next;
    logic [PW-1:0] fstep_reg, fstep_next;

    stes_pkg::note_stage_t stage_reg, stage_next;

    logic [IW-1:0] s_eff;
    logic [IW-1:0] ns_eff;
    logic [IW-1:0] s_inc;
    logic [PW-1:0] ph_eff;
    logic          fnz_eff;
    logic [PW-1:0] fstep_eff;
    logic          in_note;
    logic [PW:0]   ph_sum;
    logic [PW-1:0] ph_wrap;
    logic          move;

    assign en1      = !stage_reg.valid || stage_ready;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;
    assign stage    = stage_reg;

    // frequency mod rate by a few parallel compares
    always_comb
    begin
        fsub = '0;
        for (int j = 1; j <= int'(Q_MAX); j++)
        begin
            if ({1'b0, {(PW - FW){1'b0}}, in_item.freq_hz} >= (PW + 1)'(j * SAMPLE_RATE))
            begin
                fsub = (PW + 1)'(j * SAMPLE_RATE);
            end
        end
        fmod     = PW'({1'b0, {(PW - FW){1'b0}}, in_item.freq_hz} - fsub);
        len_prod = PRW'(in_item.duration_ms) * PRW'(LEN_MULT);
    end

    always_comb
    begin
        v0_next     = en0 ? in_valid : v0_reg;
        start0_next = start0_reg;
        fnz0_next   = fnz0_reg;
        fmod0_next  = fmod0_reg;
        len0_next   = len0_reg;
        if (in_valid && en0)
        begin
            start0_next = in_item.start_note;
            fnz0_next   = (in_item.freq_hz != '0);
            fmod0_next  = fmod;
            len0_next   = len_prod[stes_pkg::LEN_SHIFT +: IW];
        end
    end

    always_comb
    begin
        move      = v0_reg && en1;
        s_eff     = start0_reg ? '0 : idx_reg;
        ns_eff    = start0_reg ? len0_reg : len_reg;
        ph_eff    = start0_reg ? '0 : phase_reg;
        fnz_eff   = start0_reg ? fnz0_reg : fnz_reg;
        fstep_eff = start0_reg ? fmod0_reg : fstep_reg;
        in_note   = s_eff < ns_eff;
        s_inc     = s_eff + IW'(1);
        ph_sum    = {1'b0, ph_eff} + {1'b0, fstep_eff};
        ph_wrap   = (ph_sum >= RATE_X) ? PW'(ph_sum - RATE_X) : ph_sum[PW-1:0];

        idx_next   = idx_reg;
        len_next   = len_reg;
        phase_next = phase_reg;
        fnz_next   = fnz_reg;
        fstep_next = fstep_reg;
        stage_next = stage_reg;
        if (en1)
        begin
            stage_next.valid = v0_reg;
        end
        if (move)
        begin
            idx_next   = in_note ? s_inc : s_eff;
            len_next   = ns_eff;
            phase_next = in_note ? ph_wrap : ph_eff;
            fnz_next   = fnz_eff;
            fstep_next = fstep_eff;

            stage_next.flags.active = in_note && fnz_eff;
            stage_next.flags.done   = in_note && (s_inc == ns_eff);
            stage_next.flags.past   = !in_note;
            stage_next.flags.pos    = ({ph_eff, 1'b0} <= RATE_X);
            stage_next.s            = s_eff;
            stage_next.ns           = ns_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
            phase_reg <= '0;
            fnz_reg   <= 1'b0;
            fstep_reg <= '0;
            stage_reg <= '0;
        end
        else
        begin
            v0_reg    <= v0_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            phase_reg <= phase_next;
            fnz_reg   <= fnz_next;
            fstep_reg <= fstep_next;
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start0_reg <= start0_next;
        fnz0_reg   <= fnz0_next;
        fmod0_reg  <= fmod0_next;
        len0_reg   <= len0_next;
    end

endmodule

// File: hw/rtl/stes_env_gain.sv
// Raised-cosine attack/release gain: envelope table and its lookup stage.
// Depends on stes_pkg.
module stes_env_gain #(
    parameter int unsigned SAMPLE_RATE = stes_pkg::SAMPLE_RATE_DEF,
    parameter int unsigned ENV_MS      = stes_pkg::ENV_MS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stes_pkg::note_stage_t note,
    output logic                  note_ready,
    output stes_pkg::gain_stage_t stage,
    input  logic                  stage_ready
);

    localparam int IW = stes_pkg::IDX_W;
    localparam int GW = stes_pkg::GAIN_W;
    localparam int unsigned ENV_LEN = ENV_MS * SAMPLE_RATE / 1000;
    localparam int unsigned ENV_DIV = (ENV_LEN == 0) ? 1 : 2 * ENV_LEN;
    localparam int ENV_AW = (ENV_LEN < 2) ? 1 : $clog2(ENV_LEN + 1);
    localparam logic [IW-1:0] ENV_LEN_X = IW'(ENV_LEN);

    logic [GW-1:0] env_rom [ENV_LEN + 1];

    // Q30 Taylor sine squared, lower half computed, upper half mirrored
    for (genvar k = 0; k <= int'(ENV_LEN); k++)
    begin : g_rom
        localparam logic [63:0] N     = 64'(ENV_LEN);
        localparam logic [63:0] K     = 64'(k);
        localparam bit          UPPER = (64'd2 * K > N);
        localparam logic [63:0] M     = UPPER ? N - K : K;
        localparam logic [63:0] A     = (stes_pkg::PI_Q30 * M) / 64'(ENV_DIV);
        localparam logic [63:0] A2    = (A * A) >> 30;
        localparam logic [63:0] A3    = (A2 * A) >> 30;
        localparam logic [63:0] A5    = (A3 * A2) >> 30;
        localparam logic [63:0] A7    = (A5 * A2) >> 30;
        localparam logic [63:0] S     = A - A3 / 64'd6 + A5 / 64'd120 - A7 / 64'd5040;
        localparam logic [63:0] H     = (S * S) >> 30;
        localparam logic [63:0] H16   = (H + 64'd8192) >> 14;
        localparam logic [63:0] ENTRY =
            (K >= N) ? 64'd65536 : (UPPER ? 64'd65536 - H16 : H16);
        assign env_rom[k] = ENTRY[GW-1:0];
    end

    logic          en2;
    logic          lo;
    logic          hi;
    logic [IW-1:0] addr_full;
    logic [ENV_AW-1:0] addr;
    logic [GW-1:0] gain;

    stes_pkg::gain_stage_t stage_reg, stage_next;

    assign en2        = !stage_reg.valid || stage_ready;
    assign note_ready = en2;
    assign stage      = stage_reg;

    always_comb
    begin
        lo        = note.s < ENV_LEN_X;
        hi        = (note.ns > ENV_LEN_X) && (note.s >= IW'(note.ns - ENV_LEN_X));
        addr_full = lo ? note.s : IW'(note.ns - note.s);
        addr      = (lo || hi) ? addr_full[ENV_AW-1:0] : '0;
        gain      = (lo || hi) ? env_rom[addr] : stes_pkg::GAIN_ONE;

        stage_next = stage_reg;
        if (en2)
        begin
            stage_next.valid = note.valid;
            if (note.valid)
            begin
                stage_next.flags = note.flags;
                stage_next.gain  = gain;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

// File: hw/rtl/stes_amp.sv
// Amplitude pipeline: volume * gain * 32767 / (255 * 65536), sign, output register.
// Depends on stes_pkg.
module stes_amp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [stes_pkg::VOL_W-1:0] volume,
    input  stes_pkg::gain_stage_t gain_in,
    output logic                  gain_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output stes_pkg::out_item_t   out_item
);

    localparam int GW = stes_pkg::GAIN_W;
    localparam int VW = stes_pkg::VOL_W;
    localparam int XW = VW + GW;
    localparam int YW = XW + 15;
    localparam int ZW = YW - 16;
    localparam int RW = stes_pkg::RECIP_W;
    localparam int QW = ZW + RW;
    localparam int SW = stes_pkg::SMP_W;

    logic en3, en4, en5, en6;

    logic                  v3_reg, v3_next;
    stes_pkg::tone_flags_t f3_reg, f3_next;
    logic [XW-1:0]         x3_reg, x3_next;

    logic                  v4_reg, v4_next;
    stes_pkg::tone_flags_t f4_reg, f4_next;
    logic [ZW-1:0]         z4_reg, z4_next;

    logic                  v5_reg, v5_next;
    stes_pkg::tone_flags_t f5_reg, f5_next;
    logic [SW-1:0]         mag5_reg, mag5_next;

    logic                  ov_reg, ov_next;
    stes_pkg::out_item_t   out_reg, out_next;

    logic [YW-1:0] y;
    logic [QW-1:0] q;

    assign en6        = !ov_reg || out_ready;
    assign en5        = !v5_reg || en6;
    assign en4        = !v4_reg || en5;
    assign en3        = !v3_reg || en4;
    assign gain_ready = en3;
    assign out_valid  = ov_reg;
    assign out_item   = out_reg;

    always_comb
    begin
        y = {x3_reg, 15'd0} - YW'(x3_reg);
        q = QW'(z4_reg) * QW'(stes_pkg::RECIP_255);

        v3_next = en3 ? gain_in.valid : v3_reg;
        f3_next = f3_reg;
        x3_next = x3_reg;
        if (en3 && gain_in.valid)
        begin
            f3_next = gain_in.flags;
            x3_next = XW'(volume) * XW'(gain_in.gain);
        end

        v4_next = en4 ? v3_reg : v4_reg;
        f4_next = f4_reg;
        z4_next = z4_reg;
        if (en4 && v3_reg)
        begin
            f4_next = f3_reg;
            z4_next = y[YW-1:16];
        end

        v5_next   = en5 ? v4_reg : v5_reg;
        f5_next   = f5_reg;
        mag5_next = mag5_reg;
        if (en5 && v4_reg)
        begin
            f5_next   = f4_reg;
            mag5_next = q[32 +: SW];
        end

        ov_next  = en6 ? v5_reg : ov_reg;
        out_next = out_reg;
        if (en6 && v5_reg)
        begin
            if (!f5_reg.active)
            begin
                out_next.sample = '0;
            end
            else if (f5_reg.pos)
            begin
                out_next.sample = mag5_reg;
            end
            else
            begin
                out_next.sample = SW'(SW'(0) - mag5_reg);
            end
            out_next.note_done = f5_reg.done;
            out_next.past_end  = f5_reg.past;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f3_reg   <= f3_next;
        x3_reg   <= x3_next;
        f4_reg   <= f4_next;
        z4_reg   <= z4_next;
        f5_reg   <= f5_next;
        mag5_reg <= mag5_next;
        out_reg  <= out_next;
    end

endmodule

// File: hw/rtl/square_tone_envelope_synth.sv
// Top level of the square tone envelope synth: volume register and pipeline.
// Depends on stes_pkg, stes_note_ctrl, stes_env_gain, stes_amp.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   in       | in_valid / in_ready   | in_item  (start_note, freq_hz, duration_ms)
//   out      | out_valid / out_ready | out_item (sample, note_done, past_end)
//   cfg      | cfg_valid / cfg_ready | cfg_data (volume)
//
// One transaction per cycle in and out while out_ready is held high. An input
// transaction passes seven registers (input reg, note state, envelope table, three
// amplitude stages, output reg) before it reaches out_item. Every stage has its own
// valid bit, so a stalled output only blocks in_ready once all stages are full.
// Reset empties the pipeline, clears note state (every tick past end) and sets
// volume to 200.
module square_tone_envelope_synth #(
    parameter int unsigned SAMPLE_RATE = stes_pkg::SAMPLE_RATE_DEF,
    parameter int unsigned ENV_MS      = stes_pkg::ENV_MS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  stes_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output stes_pkg::out_item_t         out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [stes_pkg::VOL_W-1:0]  cfg_data
);

    logic [stes_pkg::VOL_W-1:0] volume_reg, volume_next;

    stes_pkg::note_stage_t note_stage;
    logic                  note_ready;
    stes_pkg::gain_stage_t gain_stage;
    logic                  gain_ready;

    assign cfg_ready   = 1'b1;
    assign volume_next = (cfg_valid && cfg_ready) ? cfg_data : volume_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg <= stes_pkg::VOLUME_RESET;
        end
        else
        begin
            volume_reg <= volume_next;
        end
    end

    stes_note_ctrl #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_note_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .stage       (note_stage),
        .stage_ready (note_ready)
    );

    stes_env_gain #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .ENV_MS      (ENV_MS)
    ) u_env_gain (
        .clk         (clk),
        .rst_n       (rst_n),
        .note        (note_stage),
        .note_ready  (note_ready),
        .stage       (gain_stage),
        .stage_ready (gain_ready)
    );

    stes_amp u_amp (
        .clk        (clk),
        .rst_n      (rst_n),
        .volume     (volume_reg),
        .gain_in    (gain_stage),
        .gain_ready (gain_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
